// File: rtl/bucl_pkg.sv
// ---------------------------------------------------------------------------
// bucl_pkg
// Shared types and defaults for the bounded unique compacting list.
// ---------------------------------------------------------------------------
package bucl_pkg;

  localparam int CAPACITY_DEF    = 16;
  localparam int HANDLE_BITS_DEF = 32;

  // Fixed field widths of the command and result ports
  localparam int HANDLE_PORT_W = 32;
  localparam int POS_W         = 8;
  localparam int ACTION_W      = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT   = 2'd0,
    ACT_DEL_AT   = 2'd1,
    ACT_DEL_KEY  = 2'd2,
    ACT_READ     = 2'd3
  } action_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;   // write the handle into the cell at the fill point
    logic del;   // close the gap at the given index
  } cmd_t;

endpackage

// File: rtl/bucl_cell.sv
// ---------------------------------------------------------------------------
// bucl_cell
// One list slot: holds an entry, compares it against the broadcast handle
// and takes its upper neighbor's entry when a gap closes at or below it.
// ---------------------------------------------------------------------------
module bucl_cell #(
  parameter int IDX   = 0,
  parameter int W     = 32,
  parameter int CNT_W = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bucl_pkg::cmd_t    cmd,
  input  logic [CNT_W-1:0]  fill,
  input  logic [CNT_W-1:0]  gap,
  input  logic [W-1:0]      handle,
  input  logic [W-1:0]      next_val,
  output logic [W-1:0]      val,
  output logic              match
);

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;
  logic         live;
  logic         shift;
  logic         wr;

  assign live  = CNT_W'(IDX) < fill;
  assign match = live && (val_r == handle);

  // Shift down only within the live range; the old last slot stays stale
  assign shift = cmd.del && (CNT_W'(IDX) >= gap) && (CNT_W'(IDX + 1) < fill);
  assign wr    = cmd.ins && (CNT_W'(IDX) == fill);

  always_comb begin
    priority if (wr) begin
      val_nxt = handle;
    end else if (shift) begin
      val_nxt = next_val;
    end else begin
      val_nxt = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else begin
      val_r <= val_nxt;
    end
  end

  assign val = val_r;

endmodule

// File: rtl/bounded_unique_compacting_list.sv
// ---------------------------------------------------------------------------
// bounded_unique_compacting_list
// Ordered list of unique handles with append, delete-at, delete-by-handle
// and clamped read.
// ---------------------------------------------------------------------------
// Takes one command per clock: busy never rises, and every transfer on
// start gives exactly one result, registered and shown on the out_ ports
// with out_valid high for a single cycle. The receiver cannot stall, so
// capture the result on that cycle. Each slot is a cell that compares its
// entry with the handle and can take its neighbor's entry, so a lookup plus
// a full compaction run in all cells at once; the handle compare across all
// cells and the fill update set the clock-to-clock path. Handles are kept
// to their low HANDLE_BITS bits (at most 32). Reset clears every slot.
// ---------------------------------------------------------------------------
module bounded_unique_compacting_list #(
  parameter int CAPACITY    = bucl_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = bucl_pkg::HANDLE_BITS_DEF,
  localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [bucl_pkg::ACTION_W-1:0]      in_action,
  input  logic [bucl_pkg::HANDLE_PORT_W-1:0] in_handle,
  input  logic signed [bucl_pkg::POS_W-1:0]  in_position,
  output logic                               out_valid,
  output logic                               out_ok,
  output logic [bucl_pkg::HANDLE_PORT_W-1:0] out_read_value,
  output logic [CNT_W-1:0]                   out_count
);

  localparam int W     = (HANDLE_BITS < bucl_pkg::HANDLE_PORT_W) ?
                         HANDLE_BITS : bucl_pkg::HANDLE_PORT_W;
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > bucl_pkg::POS_W) ? CNT_W : bucl_pkg::POS_W;

  logic [CNT_W-1:0]    fill_r;
  logic [CNT_W-1:0]    fill_nxt;
  logic                out_valid_r;
  logic                out_ok_r;
  logic [bucl_pkg::HANDLE_PORT_W-1:0] out_read_value_r;
  logic [CNT_W-1:0]    out_count_r;

  logic                accept;
  bucl_pkg::action_t   act;
  bucl_pkg::cmd_t      cmd;
  logic [W-1:0]        handle;
  logic [W-1:0]        vals [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic                hit;
  logic [CNT_W-1:0]    key_idx;
  logic [CNT_W-1:0]    gap;
  logic                pos_neg;
  logic                pos_live;
  logic [CNT_W-1:0]    pos_cnt;
  logic [CNT_W-1:0]    rd_cnt;
  logic [IDX_W-1:0]    rd_idx;
  logic                ok;
  logic [bucl_pkg::HANDLE_PORT_W-1:0] rd_val;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign act    = bucl_pkg::action_t'(in_action);
  assign handle = in_handle[W-1:0];

  // Live entries are unique, so at most one cell matches
  assign hit = |match;
  always_comb begin
    key_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (match[i]) begin
        key_idx = key_idx | CNT_W'(i);
      end
    end
  end

  assign pos_neg  = in_position[bucl_pkg::POS_W-1];
  assign pos_live = !pos_neg &&
                    (CMP_W'(in_position[bucl_pkg::POS_W-2:0]) < CMP_W'(fill_r));
  assign pos_cnt  = CNT_W'(in_position[bucl_pkg::POS_W-2:0]);

  // Clamp the read position into the live range, slot 0 when empty
  always_comb begin
    priority if (pos_neg || fill_r == '0) begin
      rd_cnt = '0;
    end else if (!pos_live) begin
      rd_cnt = fill_r - CNT_W'(1);
    end else begin
      rd_cnt = pos_cnt;
    end
  end
  assign rd_idx = rd_cnt[IDX_W-1:0];

  always_comb begin
    cmd      = '0;
    gap      = key_idx;
    ok       = 1'b0;
    rd_val   = '0;
    fill_nxt = fill_r;
    unique case (act)
      bucl_pkg::ACT_INSERT: begin
        ok      = (fill_r < CNT_W'(CAPACITY)) && !hit;
        cmd.ins = accept && ok;
        if (cmd.ins) begin
          fill_nxt = fill_r + CNT_W'(1);
        end
      end
      bucl_pkg::ACT_DEL_AT: begin
        ok      = pos_live;
        gap     = pos_cnt;
        cmd.del = accept && ok;
        if (cmd.del) begin
          fill_nxt = fill_r - CNT_W'(1);
        end
      end
      bucl_pkg::ACT_DEL_KEY: begin
        ok      = hit;
        cmd.del = accept && ok;
        if (cmd.del) begin
          fill_nxt = fill_r - CNT_W'(1);
        end
      end
      bucl_pkg::ACT_READ: begin
        ok     = fill_r != '0;
        rd_val = bucl_pkg::HANDLE_PORT_W'(vals[rd_idx]);
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [W-1:0] nbr;
    if (i + 1 < CAPACITY) begin : g_nbr
      assign nbr = vals[i + 1];
    end else begin : g_last
      assign nbr = vals[i];
    end

    bucl_cell #(
      .IDX   (i),
      .W     (W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .fill     (fill_r),
      .gap      (gap),
      .handle   (handle),
      .next_val (nbr),
      .val      (vals[i]),
      .match    (match[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= accept;
    end
  end

  // Result payload, held until the next transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ok_r         <= ok;
      out_read_value_r <= rd_val;
      out_count_r      <= fill_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_read_value = out_read_value_r;
  assign out_count      = out_count_r;

endmodule
